/* src/ddoi_pkg.sv */
// ddoi_pkg: shared types, constants and helpers for the odometry integrator.
// Used by ddoi_mac, ddoi_cordic and diff_drive_odometry_integrator.
package ddoi_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int FRAC_BITS_DEF    = 16;

	// accumulator of the shared multiplier, holds the widest product with margin
	localparam int ACC_W = 88;

	// 2^31 / pi, rounded
	localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
	// CORDIC start vector, 1/K in Q30
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [23:0] INV_WB_RESET  = 24'd72018;
	localparam logic [7:0]  FWD_THR_RESET = 8'd127;

	typedef enum logic [0:0] {
		REG_INV_WHEELBASE     = 1'b0,
		REG_FORWARD_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DRAIN,
		S_POST,
		S_CORDIC,
		S_PUSH
	} state_t;

	typedef enum logic [2:0] {
		OP_WZ,
		OP_R,
		OP_BAM,
		OP_VX,
		OP_VY,
		OP_PX,
		OP_PY
	} op_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_27,
		SH_43
	} sh_sel_t;

	typedef struct packed {
		logic    issue;
		logic    first;
		sh_sel_t sh;
	} mac_ctrl_t;

	typedef struct packed {
		logic [30:0] right_speed;
		logic [30:0] left_speed;
		logic [7:0]  right_command;
		logic [7:0]  left_command;
		logic [20:0] elapsed_time;
	} tick_t;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic [31:0]        heading_angle;
		logic signed [31:0] vel_x_avg;
		logic signed [31:0] vel_y_avg;
		logic signed [31:0] turn_rate_avg;
	} pose_t;

	// arctangent of 2^-i as binary angle, truncated
	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-32:0] hi_bits;
		hi_bits = v[ACC_W-1:31];
		if (hi_bits == '0 || hi_bits == '1) begin
			return v[31:0];
		end
		return v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		logic [2:0] hi_bits;
		hi_bits = v[49:47];
		if (hi_bits == '0 || hi_bits == '1) begin
			return v[47:0];
		end
		return v[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
	endfunction

endpackage

/* src/ddoi_mac.sv */
// ddoi_mac: shared 35x17 signed multiplier with registered product and a
// shifting accumulator. Depends on ddoi_pkg.
module ddoi_mac import ddoi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctrl_t               ctrl,
	input  logic signed [34:0]      a,
	input  logic signed [16:0]      b,
	output logic signed [ACC_W-1:0] acc
);

	logic                    v_s1;
	logic                    first_s1;
	sh_sel_t                 sh_s1;
	logic signed [51:0]      pp_s1;
	logic signed [ACC_W-1:0] ext;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1    <= a * b;
		first_s1 <= ctrl.first;
		sh_s1    <= ctrl.sh;
		if (v_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q) + addend;
		end
	end

	assign ext = {{(ACC_W-52){pp_s1[51]}}, pp_s1};

	always_comb begin
		case (sh_s1)
			SH_0:    addend = ext;
			SH_16:   addend = ext <<< 16;
			SH_27:   addend = ext <<< 27;
			SH_43:   addend = ext <<< 43;
			default: addend = ext;
		endcase
	end

	assign acc = acc_q;

endmodule

/* src/ddoi_cordic.sv */
// ddoi_cordic: rotation-mode CORDIC, one micro-rotation per cycle, giving
// sine and cosine of a binary angle in Q30. Depends on ddoi_pkg.
module ddoi_cordic import ddoi_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               busy,
	output logic signed [32:0] sn,
	output logic signed [32:0] cs
);

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

	logic               run_q;
	logic [IW-1:0]      i_q;
	logic signed [32:0] x_q, y_q, z_q;
	logic               flip_q;
	logic               flip_c;
	logic [31:0]        fold_c;
	logic signed [32:0] xs, ys, at;

	// second and third quarter fold onto the first and fourth
	assign flip_c = angle[31] ^ angle[30];
	assign fold_c = {angle[31] ^ flip_c, angle[30:0]};

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = {1'b0, atan_bam(5'(i_q))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q   <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			i_q   <= '0;
		end else if (run_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == LAST) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {fold_c[31], fold_c};
			flip_q <= flip_c;
		end else if (run_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy = run_q;
	assign sn   = flip_q ? -y_q : y_q;
	assign cs   = flip_q ? -x_q : x_q;

endmodule

/* src/diff_drive_odometry_integrator.sv */
// diff_drive_odometry_integrator: top level, sequencer and pose state.
// Depends on ddoi_pkg, ddoi_mac and ddoi_cordic.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  tick    | in        | tick_valid/tick_ready  | tick_t: wheel speeds, cmds, dt
//  pose    | out       | pose_valid/pose_ready  | pose_t: x, y, heading, avgs
//  cfg     | in        | cfg_we, no wait        | cfg_index, cfg_data
//
// A transaction runs from acceptance to the result entering the output register
// through the sixteen passes of the shared multiplier and the CORDIC rotation,
// which takes one micro-rotation per cycle.
// tick_ready is high only while the sequencer is idle; a waiting result sits in
// the output register, so the next tick may be taken while pose is stalled, and
// that tick finishes only once the register has been emptied.
// Reset clears the pose state, the velocity history and the registers to their
// defaults; there is no clearing pass.
module diff_drive_odometry_integrator import ddoi_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        tick_valid,
	output logic        tick_ready,
	input  tick_t       tick,
	output logic        pose_valid,
	input  logic        pose_ready,
	output pose_t       pose
);

	state_t state_q, state_d;
	op_t    op_q, next_op;
	logic [1:0] k_q, last_k;

	logic [23:0] inv_wb_q;
	logic [7:0]  fwd_thr_q;

	// latched tick
	logic signed [32:0] d_q;     // vr - vl
	logic signed [31:0] v_q;     // linear speed
	logic [20:0]        dt_q;

	// intermediates of the current tick
	logic signed [31:0] wz_q, vx_q, vy_q;
	logic signed [53:0] r_q;     // dt * turn-rate sum

	// persistent state
	logic [31:0]        heading_q;
	logic signed [47:0] x_acc_q, y_acc_q;
	logic signed [31:0] last_wz_q, last_vx_q, last_vy_q;

	pose_t pose_q;
	logic  pose_valid_q;

	// accept-side speed forming
	logic               accept;
	logic [31:0]        rmag, lmag;
	logic signed [31:0] vr, vl;
	logic signed [32:0] d_c, s_c;

	logic signed [32:0] wsum, xsum, ysum;

	// shared unit wiring
	mac_ctrl_t               mac_ctrl;
	logic signed [34:0]      mac_a;
	logic signed [16:0]      mac_b;
	logic signed [ACC_W-1:0] acc;
	logic signed [16:0]      dt_chunk;
	logic signed [32:0]      vel_src;

	logic               cor_start, cor_busy;
	logic signed [32:0] sn, cs;

	// result extraction
	logic signed [ACC_W-1:0] acc_f, acc_bam, acc_30, acc_21;
	logic [31:0]             heading_new;
	logic signed [47:0]      pos_base, pos_new;
	logic                    load_pose;

	assign accept = tick_valid && tick_ready;

	assign rmag = {1'b0, tick.right_speed};
	assign lmag = {1'b0, tick.left_speed};
	assign vr   = (tick.right_command > fwd_thr_q) ? rmag : -rmag;
	assign vl   = (tick.left_command > fwd_thr_q) ? lmag : -lmag;
	assign d_c  = {vr[31], vr} - {vl[31], vl};
	assign s_c  = {vr[31], vr} + {vl[31], vl};

	assign wsum = {last_wz_q[31], last_wz_q} + {wz_q[31], wz_q};
	assign xsum = {last_vx_q[31], last_vx_q} + {vx_q[31], vx_q};
	assign ysum = {last_vy_q[31], last_vy_q} + {vy_q[31], vy_q};

	assign acc_f   = acc >>> FRAC_BITS;
	assign acc_bam = acc >>> (FRAC_BITS + 21);
	assign acc_30  = acc >>> 30;
	assign acc_21  = acc >>> 21;

	assign heading_new = heading_q + acc_bam[31:0];
	assign pos_base    = (op_q == OP_PX) ? x_acc_q : y_acc_q;
	assign pos_new     = sat48({{2{pos_base[47]}}, pos_base}
	                           + {{17{acc_21[32]}}, acc_21[32:0]});

	assign load_pose = (state_q == S_PUSH) && (!pose_valid_q || pose_ready);

	// heading product is split four ways, the others two
	assign last_k = (op_q == OP_BAM) ? 2'd3 : 2'd1;

	always_comb begin
		case (op_q)
			OP_WZ:   next_op = OP_R;
			OP_R:    next_op = OP_BAM;
			OP_BAM:  next_op = OP_VX;
			OP_VX:   next_op = OP_VY;
			OP_VY:   next_op = OP_PX;
			OP_PX:   next_op = OP_PY;
			OP_PY:   next_op = OP_WZ;
			default: next_op = OP_WZ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (tick_valid) state_d = S_MUL;
			end
			S_MUL: begin
				if (k_q == last_k) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_POST;
			end
			S_POST: begin
				if (op_q == OP_BAM)     state_d = S_CORDIC;
				else if (op_q == OP_PY) state_d = S_PUSH;
				else                    state_d = S_MUL;
			end
			S_CORDIC: begin
				if (!cor_busy) state_d = S_MUL;
			end
			S_PUSH: begin
				if (!pose_valid_q || pose_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs and operand selection
	always_comb begin
		tick_ready     = (state_q == S_IDLE);
		cor_start      = (state_q == S_POST) && (op_q == OP_BAM);
		mac_ctrl.issue = (state_q == S_MUL);
		mac_ctrl.first = (k_q == 2'd0);
		mac_ctrl.sh    = k_q[0] ? SH_16 : SH_0;
		dt_chunk       = k_q[0] ? {12'b0, dt_q[20:16]} : {1'b0, dt_q[15:0]};
		vel_src        = (op_q == OP_VY) ? cs : sn;
		mac_a          = '0;
		mac_b          = '0;
		case (op_q)
			OP_WZ: begin
				mac_a = {{2{d_q[32]}}, d_q};
				mac_b = k_q[0] ? {9'b0, inv_wb_q[23:16]} : {1'b0, inv_wb_q[15:0]};
			end
			OP_R: begin
				mac_a = {{2{wsum[32]}}, wsum};
				mac_b = dt_chunk;
			end
			OP_BAM: begin
				// r split at bit 27, constant at bit 16
				mac_a = k_q[1] ? {{8{r_q[53]}}, r_q[53:27]} : {8'b0, r_q[26:0]};
				mac_b = k_q[0] ? {3'b0, RAD_TO_BAM[29:16]} : {1'b0, RAD_TO_BAM[15:0]};
				case (k_q)
					2'd0:    mac_ctrl.sh = SH_0;
					2'd1:    mac_ctrl.sh = SH_16;
					2'd2:    mac_ctrl.sh = SH_27;
					default: mac_ctrl.sh = SH_43;
				endcase
			end
			OP_VX, OP_VY: begin
				mac_a = {{2{vel_src[32]}}, vel_src};
				mac_b = k_q[0] ? {v_q[31], v_q[31:16]} : {1'b0, v_q[15:0]};
			end
			OP_PX: begin
				mac_a = {{2{xsum[32]}}, xsum};
				mac_b = dt_chunk;
			end
			OP_PY: begin
				mac_a = {{2{ysum[32]}}, ysum};
				mac_b = dt_chunk;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	// control and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_WZ;
			k_q          <= '0;
			inv_wb_q     <= INV_WB_RESET;
			fwd_thr_q    <= FWD_THR_RESET;
			heading_q    <= '0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
			last_wz_q    <= '0;
			last_vx_q    <= '0;
			last_vy_q    <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_INV_WHEELBASE:     inv_wb_q  <= cfg_data;
					REG_FORWARD_THRESHOLD: fwd_thr_q <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (accept) begin
				op_q <= OP_WZ;
				k_q  <= '0;
			end else if (state_q == S_MUL && k_q != last_k) begin
				k_q <= k_q + 2'd1;
			end else if (state_q == S_POST) begin
				op_q <= next_op;
				k_q  <= '0;
			end

			if (state_q == S_POST) begin
				case (op_q)
					OP_BAM:  heading_q <= heading_new;
					OP_PX:   x_acc_q   <= pos_new;
					OP_PY:   y_acc_q   <= pos_new;
					default: ;
				endcase
			end

			// history moves on as the result leaves for the output register
			if (load_pose) begin
				last_wz_q    <= wz_q;
				last_vx_q    <= vx_q;
				last_vy_q    <= vy_q;
				pose_valid_q <= 1'b1;
			end else if (pose_ready) begin
				pose_valid_q <= 1'b0;
			end
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q  <= d_c;
			v_q  <= s_c[32:1];
			dt_q <= tick.elapsed_time;
		end
		if (state_q == S_POST) begin
			case (op_q)
				OP_WZ:   wz_q <= sat32(acc_f);
				OP_R:    r_q  <= acc[53:0];
				OP_VX:   vx_q <= sat32(acc_30);
				OP_VY:   vy_q <= sat32(acc_30);
				default: ;
			endcase
		end
		if (load_pose) begin
			pose_q.pos_x         <= x_acc_q;
			pose_q.pos_y         <= y_acc_q;
			pose_q.heading_angle <= heading_q;
			pose_q.vel_x_avg     <= xsum[32:1];
			pose_q.vel_y_avg     <= ysum[32:1];
			pose_q.turn_rate_avg <= wsum[32:1];
		end
	end

	ddoi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	ddoi_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (heading_new),
		.busy   (cor_busy),
		.sn     (sn),
		.cs     (cs)
	);

	assign pose_valid = pose_valid_q;
	assign pose       = pose_q;

	// a new tick always starts with the turn-rate product
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL && op_q == OP_WZ))
		else $error("tick accepted without starting the turn-rate product");

	// a result appears only out of the push step
	a_pose_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose_valid) |-> $past(state_q == S_PUSH))
		else $error("pose raised outside the push step");

	// the rotator runs only while the sequencer waits for it
	a_cordic_owned: assert property (@(posedge clk) disable iff (!arst_n)
		cor_busy |-> (state_q == S_CORDIC))
		else $error("cordic busy outside its step");

	// results are read only after the product pipeline has drained
	a_post_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST) |-> $past(state_q == S_DRAIN))
		else $error("post step without drain");

	// velocity history holds while a result is stalled
	a_history_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && !pose_ready) |=> ($stable(last_vx_q) && $stable(last_wz_q)))
		else $error("history moved while pose stalled");

endmodule

/* tb/tb_diff_drive_odometry_integrator.sv */
`timescale 1ns / 100ps
// tb_diff_drive_odometry_integrator: self-checking bench for the odometry integrator.
// Needs ddoi_pkg and diff_drive_odometry_integrator; every pose but those of 'known'
// rows is predicted by a fixed-point integrator kept inside this file.
module tb_diff_drive_odometry_integrator;
	import ddoi_pkg::*;

	localparam int CORDIC_ITERS = 24;
	localparam int FRAC         = 16;

	// random part: items per register setting, and the number of settings
	localparam int PHASE_ITEMS = 250;
	localparam int PHASES      = 7;

	// receiver: one long hold-off once this many poses have been taken
	localparam int HOLD_AFTER = 400;
	localparam int LONG_HOLD  = 1500;

	// the tail wait covers the passage of two ticks through the block
	localparam int TAIL_CYCLES = 120;
	localparam int CYCLE_LIMIT = 2500000;

	// 2^31 / pi, and 1/K of the CORDIC in Q30
	localparam longint TURN_PER_RAD = 64'sd683565276;
	localparam longint CORDIC_START = 64'sd652032874;

	// arctan(2^-i) in binary angle units, truncated
	localparam logic [31:0] ATAN_TURN [0:CORDIC_ITERS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	localparam pose_t REST_POSE = '0;

	// one row of the directed part; 'known' rows carry a pose read straight off the spec
	typedef struct packed {
		tick_t stim;
		logic  known;
		pose_t want;
	} odo_case_t;

	// all rows run with the register defaults (inv_wheelbase 72018, threshold 127)
	localparam int DIR_ROWS = 20;
	localparam odo_case_t DIRECTED [0:DIR_ROWS-1] = '{
		// robot at rest straight after reset: pose stays at the origin
		'{'{31'd0, 31'd0, 8'd0, 8'd0, 21'd0}, 1'b1, REST_POSE},
		'{'{31'd0, 31'd0, 8'd255, 8'd255, 21'h1FFFFF}, 1'b1, REST_POSE},
		// 1 m/s straight ahead, twice so the trapezoid sees a history
		'{'{31'd65536, 31'd65536, 8'd200, 8'd200, 21'd52429}, 1'b0, REST_POSE},
		'{'{31'd65536, 31'd65536, 8'd200, 8'd200, 21'd52429}, 1'b0, REST_POSE},
		// commands either side of the threshold: turn on the spot, both ways
		'{'{31'd65536, 31'd65536, 8'd128, 8'd127, 21'd52429}, 1'b0, REST_POSE},
		'{'{31'd65536, 31'd65536, 8'd127, 8'd128, 21'd52429}, 1'b0, REST_POSE},
		// reversing for exactly one second
		'{'{31'd131072, 31'd131072, 8'd0, 8'd0, 21'h100000}, 1'b0, REST_POSE},
		// top speed ahead for 1 s, then spins that saturate the turn rate, interval over 1 s
		'{'{31'h7FFFFFFF, 31'h7FFFFFFF, 8'd255, 8'd255, 21'h100000}, 1'b0, REST_POSE},
		'{'{31'h7FFFFFFF, 31'h7FFFFFFF, 8'd255, 8'd0, 21'h1FFFFF}, 1'b0, REST_POSE},
		'{'{31'h7FFFFFFF, 31'h7FFFFFFF, 8'd0, 8'd255, 21'h1FFFFF}, 1'b0, REST_POSE},
		// full reverse, velocities saturate
		'{'{31'h7FFFFFFF, 31'h7FFFFFFF, 8'd0, 8'd0, 21'h1FFFFF}, 1'b0, REST_POSE},
		// one wheel at full speed, the other stopped
		'{'{31'h7FFFFFFF, 31'd0, 8'd255, 8'd0, 21'd52429}, 1'b0, REST_POSE},
		'{'{31'd0, 31'h7FFFFFFF, 8'd0, 8'd255, 21'd52429}, 1'b0, REST_POSE},
		// zero interval: pose holds, averages still move
		'{'{31'd327680, 31'd327680, 8'd255, 8'd0, 21'd0}, 1'b0, REST_POSE},
		// tight fast arc, heading wraps through several turns
		'{'{31'd3276800, 31'd0, 8'd255, 8'd0, 21'h100000}, 1'b0, REST_POSE},
		'{'{31'd3276800, 31'd0, 8'd255, 8'd0, 21'h100000}, 1'b0, REST_POSE},
		'{'{31'd3276800, 31'd0, 8'd255, 8'd0, 21'h100000}, 1'b0, REST_POSE},
		'{'{31'd3276800, 31'd0, 8'd255, 8'd0, 21'h100000}, 1'b0, REST_POSE},
		// alternating bit patterns through every field
		'{'{31'h2AAAAAAA, 31'h55555555, 8'hAA, 8'h55, 21'h0AAAAA}, 1'b0, REST_POSE},
		'{'{31'h55555555, 31'h2AAAAAAA, 8'h55, 8'hAA, 21'h155555}, 1'b0, REST_POSE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        tick_valid;
	logic        tick_ready;
	tick_t       tick;
	logic        pose_valid;
	logic        pose_ready;
	pose_t       pose;

	// predictor copy of the registers and of the pose state
	logic [23:0] inv_wb;
	logic [7:0]  fwd_thr;
	logic [31:0] heading_bam;
	longint      x_pos, y_pos;
	longint      prev_vx, prev_vy, prev_turn;

	pose_t expected_poses [$];
	int    poses_received = 0;
	int    mismatches = 0;
	int    cycle_count = 0;

	diff_drive_odometry_integrator #(
		.CORDIC_STEPS(CORDIC_ITERS),
		.FRAC_BITS   (FRAC)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.tick      (tick),
		.pose_valid(pose_valid),
		.pose_ready(pose_ready),
		.pose      (pose)
	);

	always #6 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clamp48(input longint v);
		if (v > 64'sd140737488355327) return 64'sd140737488355327;
		if (v < -64'sd140737488355328) return -64'sd140737488355328;
		return v;
	endfunction

	// One odometry step: signed wheel speeds, heading by trapezoid, CORDIC on the new
	// heading, then x and y by trapezoid. Updates the predictor state.
	function automatic pose_t integrate_tick(input tick_t t);
		longint vr, vl, v, wz, wsum, dt;
		longint cx, cy, cz, nx, sn, cs, vx, vy, xsum, ysum;
		logic signed [95:0] turn_prod;
		logic [31:0] folded;
		logic flip;
		int i;
		pose_t p;
		dt = longint'(t.elapsed_time);
		vr = (t.right_command > fwd_thr) ? longint'(t.right_speed) : -longint'(t.right_speed);
		vl = (t.left_command > fwd_thr) ? longint'(t.left_speed) : -longint'(t.left_speed);
		v = (vr + vl) >>> 1;
		wz = clamp32(((vr - vl) * longint'(inv_wb)) >>> FRAC);
		wsum = prev_turn + wz;

		// floor(dt * wsum * 2^31/pi / 2^(F+21)), kept modulo one turn
		turn_prod = dt * wsum;
		turn_prod = turn_prod * TURN_PER_RAD;
		heading_bam = heading_bam + turn_prod[FRAC+21 +: 32];

		// fold into [-1/4, 1/4) turn; the folded half comes back negated
		flip = (heading_bam[31:30] == 2'b01) || (heading_bam[31:30] == 2'b10);
		folded = flip ? heading_bam - 32'h8000_0000 : heading_bam;
		cz = longint'($signed(folded));
		cx = CORDIC_START;
		cy = 0;
		for (i = 0; i < CORDIC_ITERS; i++) begin
			if (cz >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				cz = cz - longint'(ATAN_TURN[i]);
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				cz = cz + longint'(ATAN_TURN[i]);
			end
			cx = nx;
		end
		sn = flip ? -cy : cy;
		cs = flip ? -cx : cx;

		vx = clamp32((v * sn) >>> 30);
		vy = clamp32((v * cs) >>> 30);
		xsum = prev_vx + vx;
		ysum = prev_vy + vy;
		x_pos = clamp48(x_pos + ((dt * xsum) >>> 21));
		y_pos = clamp48(y_pos + ((dt * ysum) >>> 21));

		p.pos_x = x_pos[47:0];
		p.pos_y = y_pos[47:0];
		p.heading_angle = heading_bam;
		p.vel_x_avg = 32'(xsum >>> 1);
		p.vel_y_avg = 32'(ysum >>> 1);
		p.turn_rate_avg = 32'(wsum >>> 1);
		prev_vx = vx;
		prev_vy = vy;
		prev_turn = wz;
		return p;
	endfunction

	function automatic logic [30:0] random_speed();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return 31'($urandom);
			default: return 31'($urandom_range(0, 327680));
		endcase
	endfunction

	// commands cluster on the threshold so both directions and the edge get hit
	function automatic logic [7:0] random_command();
		case ($urandom_range(0, 3))
			0: return fwd_thr;
			1: return fwd_thr + 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_INV_WHEELBASE: inv_wb = value;
			REG_FORWARD_THRESHOLD: fwd_thr = value[7:0];
			default: ;
		endcase
	endtask

	// Offer one tick and hold it until taken; the pose is predicted at acceptance.
	task automatic send_tick(input tick_t t, input logic known, input pose_t want);
		pose_t model_pose;
		@(negedge clk);
		tick_valid <= 1'b1;
		tick <= t;
		do @(posedge clk); while (!tick_ready);
		model_pose = integrate_tick(t);
		expected_poses.push_back(known ? want : model_pose);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		tick_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop offering and wait for every outstanding pose; the block is idle after
	task automatic drain_results();
		@(negedge clk);
		tick_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (want !== got) begin
			$display("%0t: pose.%s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Pose transactions are compared against the oldest prediction.
	always @(posedge clk) begin : pose_check
		pose_t want;
		if (arst_n && pose_valid && pose_ready) begin
			if (expected_poses.size() == 0) begin
				$display("%0t: pose transaction with none expected, got %h", $time, pose);
				mismatches++;
			end else begin
				want = expected_poses.pop_front();
				check_field("pos_x", want.pos_x, pose.pos_x);
				check_field("pos_y", want.pos_y, pose.pos_y);
				check_field("heading_angle", want.heading_angle, pose.heading_angle);
				check_field("vel_x_avg", want.vel_x_avg, pose.vel_x_avg);
				check_field("vel_y_avg", want.vel_y_avg, pose.vel_y_avg);
				check_field("turn_rate_avg", want.turn_rate_avg, pose.turn_rate_avg);
			end
			poses_received++;
		end
	end

	// Receiver: stretches of always-ready, coin-toss and stalled, plus one long hold-off
	// that fills the block and pushes back on the tick channel.
	initial begin : pose_sink
		int mode;
		int stretch;
		bit held;
		held = 1'b0;
		pose_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && poses_received >= HOLD_AFTER) begin
				held = 1'b1;
				@(negedge clk);
				pose_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end
			mode = $urandom_range(0, 9);
			stretch = $urandom_range(1, 48);
			repeat (stretch) begin
				@(negedge clk);
				if (mode < 4) pose_ready <= 1'b1;
				else if (mode < 7) pose_ready <= 1'($urandom_range(0, 1));
				else pose_ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d poses outstanding", $time, expected_poses.size());
			$display("diff_drive_odometry_integrator regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int ph, n, row, burst_left, gap;
		tick_t t;
		logic [23:0] wb;
		logic [7:0]  thr;

		tick_valid = 1'b0;
		tick = '0;
		cfg_we = 1'b0;
		cfg_index = REG_INV_WHEELBASE;
		cfg_data = '0;
		inv_wb = INV_WB_RESET;
		fwd_thr = FWD_THR_RESET;
		heading_bam = '0;
		x_pos = 0;
		y_pos = 0;
		prev_vx = 0;
		prev_vy = 0;
		prev_turn = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, back to back, register defaults
		for (row = 0; row < DIR_ROWS; row++)
			send_tick(DIRECTED[row].stim, DIRECTED[row].known, DIRECTED[row].want);
		drain_results();

		// random part: one register setting per phase, written with the block idle
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// zero inverse wheelbase: turn rate pinned at zero
					wb = 24'd0;
					thr = 8'd127;
				end
				1: begin
					wb = 24'hFFFFFF;
					thr = 8'd0;
				end
				2: begin
					// nothing exceeds 255, so every wheel runs in reverse
					wb = 24'd1;
					thr = 8'd255;
				end
				3: begin
					wb = 24'd131072;
					thr = 8'd128;
				end
				4, 5: begin
					wb = 24'($urandom_range(1, 24'hFFFFFF));
					thr = 8'($urandom);
				end
				default: begin
					wb = INV_WB_RESET;
					thr = FWD_THR_RESET;
				end
			endcase
			write_reg(REG_INV_WHEELBASE, wb);
			write_reg(REG_FORWARD_THRESHOLD, {16'd0, thr});

			// bursts of back-to-back ticks with gaps of random length between them
			burst_left = 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
					if (gap != 0) pause_sender(gap);
				end
				t.right_speed = random_speed();
				t.left_speed = random_speed();
				t.right_command = random_command();
				t.left_command = random_command();
				case ($urandom_range(0, 9))
					0: t.elapsed_time = '0;
					1: t.elapsed_time = 21'h100000;
					2: t.elapsed_time = 21'($urandom);
					default: t.elapsed_time = 21'($urandom_range(10000, 110000));
				endcase
				send_tick(t, 1'b0, REST_POSE);
				burst_left--;
			end
			drain_results();
		end

		// anything arriving now is a stray pose
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("diff_drive_odometry_integrator regression: pass");
		end else begin
			$display("diff_drive_odometry_integrator regression: fail");
		end
		$finish;
	end

endmodule
